FILE: design/sre_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// sre_pkg: shared types and constants for the segment/rectangle edge crossing
// Widths of coordinates and of the intermediate products.
// ---------------------------------------------------------------------------
package sre_pkg;
  localparam int unsigned CoordBits = 16;
  localparam int unsigned DiffBits  = CoordBits + 1;
  localparam int unsigned NumBits   = 2 * CoordBits + 4;
  localparam int unsigned EdgeCount = 4;
  localparam int unsigned InBytes   = (12 * CoordBits + 7) / 8;
  localparam int unsigned OutBytes  = (4 * CoordBits + 1 + 7) / 8;

  typedef logic signed [CoordBits-1:0] coord_t;
  typedef logic signed [DiffBits-1:0]  diff_t;
  typedef logic signed [NumBits-1:0]   num_t;

  typedef struct packed {
    coord_t l;
    coord_t t;
    coord_t r;
    coord_t b;
  } rect_t;

  typedef struct packed {
    coord_t x1;
    coord_t y1;
    diff_t  dx;
    diff_t  dy;
    rect_t  ra;
    rect_t  rb;
  } seg_t;

  // One edge test after the compare stage: hit flag, fixed coordinate,
  // exact numerator and positive denominator of the moving coordinate.
  typedef struct packed {
    logic   hit;
    logic   vert;
    coord_t c;
    num_t   num;
    diff_t  den;
  } cand_t;
endpackage
`default_nettype wire

FILE: design/sre_edge.sv
`default_nettype none
// ---------------------------------------------------------------------------
// sre_edge: two-stage edge crossing test
// Stage one forms the products, stage two the range compares.
// ---------------------------------------------------------------------------
module sre_edge (
  input  wire logic            clk_i,
  input  wire logic            en_i,
  input  wire sre_pkg::coord_t u1_i,
  input  wire sre_pkg::diff_t  du_i,
  input  wire sre_pkg::coord_t v1_i,
  input  wire sre_pkg::diff_t  dv_i,
  input  wire sre_pkg::coord_t c_i,
  input  wire sre_pkg::coord_t ea_i,
  input  wire sre_pkg::coord_t eb_i,
  input  wire logic            vert_i,
  output sre_pkg::cand_t       cand_o
);
  logic                        ok_d, ok_q, vert_q;
  sre_pkg::diff_t              n_d, d_d;
  sre_pkg::num_t               num_d, num_q, lo_d, lo_q, hi_d, hi_q;
  sre_pkg::diff_t              d_q;
  sre_pkg::coord_t             c_q, lo_c, hi_c;
  logic signed [sre_pkg::DiffBits:0] nraw;

  always_comb begin
    nraw = {{2{c_i[sre_pkg::CoordBits-1]}}, c_i} - {{2{u1_i[sre_pkg::CoordBits-1]}}, u1_i};
    if (du_i < 0) begin
      n_d = sre_pkg::diff_t'(-nraw);
      d_d = -du_i;
    end else begin
      n_d = sre_pkg::diff_t'(nraw);
      d_d = du_i;
    end
    lo_c  = (ea_i < eb_i) ? ea_i : eb_i;
    hi_c  = (ea_i < eb_i) ? eb_i : ea_i;
    ok_d  = (du_i != '0) && (ea_i != eb_i) && (n_d >= 0) && (n_d <= d_d);
    num_d = sre_pkg::num_t'(v1_i) * sre_pkg::num_t'(d_d)
          + sre_pkg::num_t'(n_d) * sre_pkg::num_t'(dv_i);
    lo_d  = sre_pkg::num_t'(lo_c) * sre_pkg::num_t'(d_d);
    hi_d  = sre_pkg::num_t'(hi_c) * sre_pkg::num_t'(d_d);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ok_q <= ok_d; vert_q <= vert_i; c_q <= c_i; num_q <= num_d;
      lo_q <= lo_d; hi_q <= hi_d; d_q <= d_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cand_o.hit  <= ok_q && (num_q >= lo_q) && (num_q <= hi_q);
      cand_o.vert <= vert_q;
      cand_o.c    <= c_q;
      cand_o.num  <= num_q;
      cand_o.den  <= d_q;
    end
  end
endmodule
`default_nettype wire

FILE: design/sre_div.sv
`default_nettype none
// ---------------------------------------------------------------------------
// sre_div: pipelined restoring divider, one quotient bit per stage
// Quotient magnitude fits CoordBits, so only that many stages are needed.
// ---------------------------------------------------------------------------
module sre_div (
  input  wire logic            clk_i,
  input  wire logic            en_i,
  input  wire sre_pkg::num_t   num_i,
  input  wire sre_pkg::diff_t  den_i,
  output sre_pkg::coord_t      quo_o
);
  localparam int unsigned Q = sre_pkg::CoordBits;
  localparam int unsigned W = sre_pkg::NumBits;
  logic [W-1:0]             rem_q [Q+1];
  logic [W-1:0]             den_q [Q+1];
  logic [Q-1:0]             quo_q [Q+1];
  logic                     neg_q [Q+1];
  logic [W-1:0]             trial [Q];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= num_i[W-1] ? W'(-num_i) : W'(num_i);
      den_q[0] <= W'(unsigned'(den_i));
      quo_q[0] <= '0;
      neg_q[0] <= num_i[W-1];
    end
  end

  for (genvar s = 0; s < Q; s++) begin : g_st
    always_comb trial[s] = den_q[s] << (Q - 1 - s);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        den_q[s+1] <= den_q[s];
        neg_q[s+1] <= neg_q[s];
        if (rem_q[s] >= trial[s]) begin
          rem_q[s+1] <= rem_q[s] - trial[s];
          quo_q[s+1] <= quo_q[s] | (Q'(1) << (Q - 1 - s));
        end else begin
          rem_q[s+1] <= rem_q[s];
          quo_q[s+1] <= quo_q[s];
        end
      end
    end
  end

  assign quo_o = neg_q[Q] ? sre_pkg::coord_t'(-quo_q[Q]) : sre_pkg::coord_t'(quo_q[Q]);
endmodule
`default_nettype wire

FILE: design/sre_rect.sv
`default_nettype none
// ---------------------------------------------------------------------------
// sre_rect: one rectangle, an edge test per side, priority pick and division
// Outputs follow the divider, behind the edge tests and the pick register.
// ---------------------------------------------------------------------------
module sre_rect (
  input  wire logic          clk_i,
  input  wire logic          en_i,
  input  wire sre_pkg::seg_t seg_i,
  input  wire logic          sel_i,
  output logic               hit_o,
  output sre_pkg::coord_t    x_o,
  output sre_pkg::coord_t    y_o
);
  localparam int unsigned Q = sre_pkg::CoordBits;
  sre_pkg::rect_t  rc;
  sre_pkg::cand_t  cand [sre_pkg::EdgeCount];
  sre_pkg::cand_t  pick_d, pick_q;
  logic            hit_q [Q+1];
  logic            vert_q [Q+1];
  sre_pkg::coord_t c_q [Q+1];
  sre_pkg::coord_t quo;

  assign rc = sel_i ? seg_i.rb : seg_i.ra;

  // top, right, bottom, left
  sre_edge u_top (.clk_i, .en_i, .u1_i(seg_i.y1), .du_i(seg_i.dy), .v1_i(seg_i.x1),
    .dv_i(seg_i.dx), .c_i(rc.t), .ea_i(rc.l), .eb_i(rc.r), .vert_i(1'b0), .cand_o(cand[0]));
  sre_edge u_right (.clk_i, .en_i, .u1_i(seg_i.x1), .du_i(seg_i.dx), .v1_i(seg_i.y1),
    .dv_i(seg_i.dy), .c_i(rc.r), .ea_i(rc.t), .eb_i(rc.b), .vert_i(1'b1), .cand_o(cand[1]));
  sre_edge u_bot (.clk_i, .en_i, .u1_i(seg_i.y1), .du_i(seg_i.dy), .v1_i(seg_i.x1),
    .dv_i(seg_i.dx), .c_i(rc.b), .ea_i(rc.r), .eb_i(rc.l), .vert_i(1'b0), .cand_o(cand[2]));
  sre_edge u_left (.clk_i, .en_i, .u1_i(seg_i.x1), .du_i(seg_i.dx), .v1_i(seg_i.y1),
    .dv_i(seg_i.dy), .c_i(rc.l), .ea_i(rc.b), .eb_i(rc.t), .vert_i(1'b1), .cand_o(cand[3]));

  always_comb begin
    pick_d = cand[3];
    if (cand[2].hit) pick_d = cand[2];
    if (cand[1].hit) pick_d = cand[1];
    if (cand[0].hit) pick_d = cand[0];
    // keep the divider fed with a non-zero denominator on a miss
    if (!pick_d.hit) begin
      pick_d.num = '0;
      pick_d.den = sre_pkg::diff_t'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) pick_q <= pick_d;
  end

  sre_div u_div (.clk_i, .en_i, .num_i(pick_q.num), .den_i(pick_q.den), .quo_o(quo));

  // match the divider: its input stage plus one stage per quotient bit
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hit_q[0] <= pick_q.hit; vert_q[0] <= pick_q.vert; c_q[0] <= pick_q.c;
      for (int i = 1; i <= Q; i++) begin
        hit_q[i] <= hit_q[i-1]; vert_q[i] <= vert_q[i-1]; c_q[i] <= c_q[i-1];
      end
    end
  end

  always_comb begin
    hit_o = hit_q[Q];
    x_o = vert_q[Q] ? c_q[Q] : quo;
    y_o = vert_q[Q] ? quo : c_q[Q];
  end
endmodule
`default_nettype wire

FILE: design/segment_rect_edge_intersect.sv
`default_nettype none
// ---------------------------------------------------------------------------
// segment_rect_edge_intersect: segment crossing with two rectangles' edges
// Streaming top level with valid pipeline and output register.
// ---------------------------------------------------------------------------
// Takes one segment and two rectangles per cycle and returns one result per
// item. A result passes through the register stages (the edge test's product
// and compare stages, a pick stage, the divider's input stage and one divider
// stage per quotient bit, and the output register) before it is offered.
// Throughput is one item per clock while the output side takes results; the
// whole pipeline advances together and holds when the output register is full
// and stalled.
module segment_rect_edge_intersect (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // start_x, start_y, end_x, end_y, first_left/top/right/bottom,
  // second_left/top/right/bottom
  input  wire logic [8*sre_pkg::InBytes-1:0]   s_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // found, hit_first_x, hit_first_y, hit_second_x, hit_second_y
  output logic [8*sre_pkg::OutBytes-1:0]       m_axis_tdata
);
  localparam int unsigned C   = sre_pkg::CoordBits;
  localparam int unsigned Lat = C + 4;
  logic [Lat-1:0]        vld_q;
  logic                  en, ha, hb, out_vld_q;
  sre_pkg::seg_t         seg;
  sre_pkg::coord_t       ax, ay, bx, by, ex, ey;
  logic [4*C:0]          out_q;

  assign en = !out_vld_q || m_axis_tready;
  assign s_axis_tready = en;

  always_comb begin
    seg.x1 = s_axis_tdata[0 +: C];
    seg.y1 = s_axis_tdata[C +: C];
    ex     = s_axis_tdata[2*C +: C];
    ey     = s_axis_tdata[3*C +: C];
    seg.dx = sre_pkg::diff_t'(ex) - sre_pkg::diff_t'(seg.x1);
    seg.dy = sre_pkg::diff_t'(ey) - sre_pkg::diff_t'(seg.y1);
    seg.ra = {s_axis_tdata[4*C +: C], s_axis_tdata[5*C +: C],
              s_axis_tdata[6*C +: C], s_axis_tdata[7*C +: C]};
    seg.rb = {s_axis_tdata[8*C +: C], s_axis_tdata[9*C +: C],
              s_axis_tdata[10*C +: C], s_axis_tdata[11*C +: C]};
  end

  sre_rect u_ra (.clk_i, .en_i(en), .seg_i(seg), .sel_i(1'b0), .hit_o(ha), .x_o(ax), .y_o(ay));
  sre_rect u_rb (.clk_i, .en_i(en), .seg_i(seg), .sel_i(1'b1), .hit_o(hb), .x_o(bx), .y_o(by));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      vld_q     <= {vld_q[Lat-2:0], s_axis_tvalid};
      out_vld_q <= vld_q[Lat-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) out_q <= (ha && hb) ? {by, bx, ay, ax, 1'b1} : '0;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = (8*sre_pkg::OutBytes)'(out_q);
endmodule
`default_nettype wire
